@@ hw/rtl/dsts_pkg.sv @@
`timescale 1ns / 1ps

package dsts_pkg;

	// Status of one finished sample list, passed from the accumulator to the
	// result selection.
	typedef struct packed {
		logic overflow;
		logic no_split;
	} dsts_flags_t;

endpackage

@@ hw/rtl/dsts_sample_if.sv @@
`timescale 1ns / 1ps

interface dsts_sample_if #(
	parameter int VALUE_BITS  = 16,
	parameter int WEIGHT_BITS = 24
);
	logic                          valid;
	logic                          ready;
	logic signed [VALUE_BITS-1:0]  sample_value;
	logic                          is_positive;
	logic        [WEIGHT_BITS-1:0] sample_weight;
	logic                          last_sample;

	modport source (
		output valid, sample_value, is_positive, sample_weight, last_sample,
		input  ready
	);

	modport sink (
		input  valid, sample_value, is_positive, sample_weight, last_sample,
		output ready
	);
endinterface

@@ hw/rtl/dsts_result_if.sv @@
`timescale 1ns / 1ps

interface dsts_result_if #(
	parameter int ERROR_BITS     = 34,
	parameter int THRESHOLD_BITS = 17
);
	logic                             valid;
	logic                             ready;
	logic        [ERROR_BITS-1:0]     least_error;
	logic signed [THRESHOLD_BITS-1:0] threshold_sum;
	logic                             below_is_positive;
	logic                             no_split;
	logic                             overflow;

	modport source (
		output valid, least_error, threshold_sum, below_is_positive, no_split, overflow,
		input  ready
	);

	modport sink (
		input  valid, least_error, threshold_sum, below_is_positive, no_split, overflow,
		output ready
	);
endinterface

@@ hw/rtl/dsts_accum.sv @@
`timescale 1ns / 1ps

module dsts_accum
	import dsts_pkg::*;
#(
	parameter int MAX_SAMPLES = 1024,
	parameter int VALUE_BITS  = 16,
	parameter int WEIGHT_BITS = 24,
	localparam int CNT_W   = $clog2(MAX_SAMPLES + 1),
	localparam int SPLIT_W = $clog2(MAX_SAMPLES),
	localparam int SUM_W   = WEIGHT_BITS + SPLIT_W,
	localparam int DIFF_W  = SUM_W + 1,
	localparam int THR_W   = VALUE_BITS + 1
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       step,
	input  logic signed [VALUE_BITS-1:0]  value,
	input  logic                       pos,
	input  logic        [WEIGHT_BITS-1:0] weight,
	input  logic                       last,
	output logic        [SUM_W-1:0]    psum_s2,
	output logic        [SUM_W-1:0]    nsum_s2,
	output logic signed [DIFF_W-1:0]   least_d_s2,
	output logic signed [THR_W-1:0]    least_thr_s2,
	output logic        [SPLIT_W-1:0]  least_split_s2,
	output logic signed [DIFF_W-1:0]   greatest_d_s2,
	output logic signed [THR_W-1:0]    greatest_thr_s2,
	output logic        [SPLIT_W-1:0]  greatest_split_s2,
	output dsts_flags_t                flags_s2
);

	logic        [SUM_W-1:0]      psum_q, nsum_q, psum_n, nsum_n;
	logic signed [DIFF_W-1:0]     diff_q, diff_n;
	logic signed [VALUE_BITS-1:0] prev_q, prev_n;
	logic        [CNT_W-1:0]      count_q, count_n, count_m1;
	logic signed [DIFF_W-1:0]     least_d_q, least_d_n, greatest_d_q, greatest_d_n;
	logic signed [THR_W-1:0]      least_thr_q, least_thr_n, greatest_thr_q, greatest_thr_n;
	logic        [SPLIT_W-1:0]    least_split_q, least_split_n;
	logic        [SPLIT_W-1:0]    greatest_split_q, greatest_split_n;
	logic                         ovf_q, ovf_n;

	logic                         full, scoring, first, take_least, take_greatest;
	logic signed [THR_W-1:0]      thr;
	logic        [SUM_W-1:0]      wsum;
	logic signed [DIFF_W-1:0]     wdiff;

	assign full     = count_q >= CNT_W'(MAX_SAMPLES);
	assign scoring  = !full && (count_q != '0);
	assign first    = count_q == CNT_W'(1);
	assign count_m1 = count_q - CNT_W'(1);
	assign thr      = THR_W'(prev_q) + THR_W'(value);
	assign wsum     = SUM_W'(weight);
	assign wdiff    = $signed({{(DIFF_W - WEIGHT_BITS){1'b0}}, weight});

	// The running difference is kept in its own register so the split score
	// is a plain compare against the stored extremes.
	assign take_least    = scoring && (first || (diff_q < least_d_q));
	assign take_greatest = scoring && (first || (diff_q > greatest_d_q));

	always_comb begin
		psum_n           = psum_q;
		nsum_n           = nsum_q;
		diff_n           = diff_q;
		prev_n           = prev_q;
		count_n          = count_q;
		ovf_n            = ovf_q | full;
		least_d_n        = take_least ? diff_q : least_d_q;
		least_thr_n      = take_least ? thr : least_thr_q;
		least_split_n    = take_least ? count_m1[SPLIT_W-1:0] : least_split_q;
		greatest_d_n     = take_greatest ? diff_q : greatest_d_q;
		greatest_thr_n   = take_greatest ? thr : greatest_thr_q;
		greatest_split_n = take_greatest ? count_m1[SPLIT_W-1:0] : greatest_split_q;
		if (!full) begin
			if (pos) begin
				psum_n = psum_q + wsum;
				diff_n = diff_q + wdiff;
			end else begin
				nsum_n = nsum_q + wsum;
				diff_n = diff_q - wdiff;
			end
			prev_n  = value;
			count_n = count_q + CNT_W'(1);
		end
	end

	// A last sample hands its final state to the result stage and clears the
	// search for the next list.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			psum_q           <= '0;
			nsum_q           <= '0;
			diff_q           <= '0;
			prev_q           <= '0;
			count_q          <= '0;
			least_d_q        <= '0;
			least_thr_q      <= '0;
			least_split_q    <= '0;
			greatest_d_q     <= '0;
			greatest_thr_q   <= '0;
			greatest_split_q <= '0;
			ovf_q            <= 1'b0;
		end else if (step) begin
			if (last) begin
				psum_q           <= '0;
				nsum_q           <= '0;
				diff_q           <= '0;
				prev_q           <= '0;
				count_q          <= '0;
				least_d_q        <= '0;
				least_thr_q      <= '0;
				least_split_q    <= '0;
				greatest_d_q     <= '0;
				greatest_thr_q   <= '0;
				greatest_split_q <= '0;
				ovf_q            <= 1'b0;
			end else begin
				psum_q           <= psum_n;
				nsum_q           <= nsum_n;
				diff_q           <= diff_n;
				prev_q           <= prev_n;
				count_q          <= count_n;
				least_d_q        <= least_d_n;
				least_thr_q      <= least_thr_n;
				least_split_q    <= least_split_n;
				greatest_d_q     <= greatest_d_n;
				greatest_thr_q   <= greatest_thr_n;
				greatest_split_q <= greatest_split_n;
				ovf_q            <= ovf_n;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (step && last) begin
			psum_s2           <= psum_n;
			nsum_s2           <= nsum_n;
			least_d_s2        <= least_d_n;
			least_thr_s2      <= least_thr_n;
			least_split_s2    <= least_split_n;
			greatest_d_s2     <= greatest_d_n;
			greatest_thr_s2   <= greatest_thr_n;
			greatest_split_s2 <= greatest_split_n;
			flags_s2.overflow <= ovf_n;
			flags_s2.no_split <= count_n < CNT_W'(2);
		end
	end

endmodule

@@ hw/rtl/dsts_select.sv @@
`timescale 1ns / 1ps

module dsts_select
	import dsts_pkg::*;
#(
	parameter int SUM_W   = 34,
	parameter int SPLIT_W = 10,
	parameter int THR_W   = 17,
	localparam int DIFF_W = SUM_W + 1
) (
	input  logic        [SUM_W-1:0]   psum,
	input  logic        [SUM_W-1:0]   nsum,
	input  logic signed [DIFF_W-1:0]  least_d,
	input  logic signed [THR_W-1:0]   least_thr,
	input  logic        [SPLIT_W-1:0] least_split,
	input  logic signed [DIFF_W-1:0]  greatest_d,
	input  logic signed [THR_W-1:0]   greatest_thr,
	input  logic        [SPLIT_W-1:0] greatest_split,
	input  dsts_flags_t               flags,
	output logic        [SUM_W-1:0]   least_error,
	output logic signed [THR_W-1:0]   threshold_sum,
	output logic                      below_is_positive,
	output logic                      no_split,
	output logic                      overflow
);

	logic signed [DIFF_W-1:0] err_above, err_below, err;
	logic                     below;

	assign err_above = $signed({1'b0, nsum}) + least_d;
	assign err_below = $signed({1'b0, psum}) - greatest_d;

	// Equal errors favor the earlier split, then the above-is-positive sense.
	assign below = (err_below < err_above) ||
	               ((err_below == err_above) && (greatest_split < least_split));
	assign err   = below ? err_below : err_above;

	always_comb begin
		least_error       = '0;
		threshold_sum     = '0;
		below_is_positive = 1'b0;
		no_split          = 1'b0;
		overflow          = 1'b0;
		if (flags.overflow) begin
			overflow = 1'b1;
		end else if (flags.no_split) begin
			no_split = 1'b1;
		end else begin
			least_error       = err[SUM_W-1:0];
			threshold_sum     = below ? greatest_thr : least_thr;
			below_is_positive = below;
		end
	end

endmodule

@@ hw/rtl/decision_stump_threshold_search.sv @@
`timescale 1ns / 1ps
// Weighted decision stump threshold search over one feature.
// The samples channel delivers one request per sample, in ascending order of
// sample_value, each with its label, its boosting weight and a last_sample
// mark that closes the list. The result channel delivers one request per
// list: the least weighted error, the sum of the two values around the best
// split (twice the split point), the polarity, and the no_split and overflow
// flags. Nothing is returned for samples that are not marked last.
// Throughput is one sample per cycle while no last sample is held off: each
// sample updates the running sums and is checked with two compares against
// the running extremes, held in the accumulator registers. The result of a
// last sample passes from the input register through the final snapshot to
// the result register. A new list may start in the cycle after a last sample.
// When the receiver stalls, the finished result waits in the output register
// and samples keep flowing; a second finished list waits in the snapshot
// stage, and only a third last sample is held off until one is taken.
// Reset clears the running sums, counts and valid bits, so the block starts
// empty and begins a fresh list with the first sample after reset.
module decision_stump_threshold_search
	import dsts_pkg::*;
#(
	parameter int MAX_SAMPLES = 1024,
	parameter int VALUE_BITS  = 16,
	parameter int WEIGHT_BITS = 24
) (
	input  logic         clk,
	input  logic         arst_n,
	dsts_sample_if.sink  samples,
	dsts_result_if.source result
);

	localparam int SPLIT_W = $clog2(MAX_SAMPLES);
	localparam int SUM_W   = WEIGHT_BITS + SPLIT_W;
	localparam int DIFF_W  = SUM_W + 1;
	localparam int THR_W   = VALUE_BITS + 1;

	// Input register.
	logic                          valid_s1;
	logic signed [VALUE_BITS-1:0]  value_s1;
	logic                          pos_s1;
	logic        [WEIGHT_BITS-1:0] weight_s1;
	logic                          last_s1;

	// Final snapshot of a list, waiting for the result register.
	logic                          valid_s2;
	logic        [SUM_W-1:0]       psum_s2, nsum_s2;
	logic signed [DIFF_W-1:0]      least_d_s2, greatest_d_s2;
	logic signed [THR_W-1:0]       least_thr_s2, greatest_thr_s2;
	logic        [SPLIT_W-1:0]     least_split_s2, greatest_split_s2;
	dsts_flags_t                   flags_s2;

	// Result register.
	logic                          out_valid_q;
	logic        [SUM_W-1:0]       least_error_q;
	logic signed [THR_W-1:0]       threshold_sum_q;
	logic                          below_is_positive_q;
	logic                          no_split_q;
	logic                          overflow_q;

	logic                          accept, go_s1, go_s2, free_s2;
	logic        [SUM_W-1:0]       sel_error;
	logic signed [THR_W-1:0]       sel_threshold;
	logic                          sel_below, sel_no_split, sel_overflow;

	// The snapshot moves on when the result register is empty or being read.
	// A sample leaves the input register every cycle unless it closes a list
	// and the snapshot stage cannot take it.
	assign go_s2   = valid_s2 && (!out_valid_q || result.ready);
	assign free_s2 = !valid_s2 || go_s2;
	assign go_s1   = valid_s1 && (!last_s1 || free_s2);

	// The input register takes a new sample whenever it is empty or its
	// sample moves on in this cycle. Ready drops only when a last sample
	// waits there while both downstream stages are full and the receiver
	// holds off.
	assign samples.ready = !valid_s1 || go_s1;
	assign accept        = samples.valid && samples.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (go_s1) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			value_s1  <= samples.sample_value;
			pos_s1    <= samples.is_positive;
			weight_s1 <= samples.sample_weight;
			last_s1   <= samples.last_sample;
		end
	end

	dsts_accum #(
		.MAX_SAMPLES (MAX_SAMPLES),
		.VALUE_BITS  (VALUE_BITS),
		.WEIGHT_BITS (WEIGHT_BITS)
	) u_accum (
		.clk               (clk),
		.arst_n            (arst_n),
		.step              (go_s1),
		.value             (value_s1),
		.pos               (pos_s1),
		.weight            (weight_s1),
		.last              (last_s1),
		.psum_s2           (psum_s2),
		.nsum_s2           (nsum_s2),
		.least_d_s2        (least_d_s2),
		.least_thr_s2      (least_thr_s2),
		.least_split_s2    (least_split_s2),
		.greatest_d_s2     (greatest_d_s2),
		.greatest_thr_s2   (greatest_thr_s2),
		.greatest_split_s2 (greatest_split_s2),
		.flags_s2          (flags_s2)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (go_s1 && last_s1) begin
			valid_s2 <= 1'b1;
		end else if (go_s2) begin
			valid_s2 <= 1'b0;
		end
	end

	// Both polarities are scored from the snapshot and the better one is kept.
	dsts_select #(
		.SUM_W   (SUM_W),
		.SPLIT_W (SPLIT_W),
		.THR_W   (THR_W)
	) u_select (
		.psum              (psum_s2),
		.nsum              (nsum_s2),
		.least_d           (least_d_s2),
		.least_thr         (least_thr_s2),
		.least_split       (least_split_s2),
		.greatest_d        (greatest_d_s2),
		.greatest_thr      (greatest_thr_s2),
		.greatest_split    (greatest_split_s2),
		.flags             (flags_s2),
		.least_error       (sel_error),
		.threshold_sum     (sel_threshold),
		.below_is_positive (sel_below),
		.no_split          (sel_no_split),
		.overflow          (sel_overflow)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (go_s2) begin
			out_valid_q <= 1'b1;
		end else if (result.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (go_s2) begin
			least_error_q       <= sel_error;
			threshold_sum_q     <= sel_threshold;
			below_is_positive_q <= sel_below;
			no_split_q          <= sel_no_split;
			overflow_q          <= sel_overflow;
		end
	end

	assign result.valid             = out_valid_q;
	assign result.least_error       = least_error_q;
	assign result.threshold_sum     = threshold_sum_q;
	assign result.below_is_positive = below_is_positive_q;
	assign result.no_split          = no_split_q;
	assign result.overflow          = overflow_q;

endmodule
